### design/tmwf_pkg.sv
// Shared types for the trimmed-mean window filter.
// Holds the pipeline load strobes passed from the top level to each channel.
// No dependencies.
`default_nettype none

package tmwf_pkg;

  // Load strobes for the four pipeline registers of one channel.
  typedef struct packed {
    logic ld_hist;  // shift a new sample into the window
    logic ld_keep;  // capture the ranked and trimmed window
    logic ld_sum;   // capture the sum of the kept entries
    logic ld_avg;   // capture the divided result
  } tmwf_ctrl_t;

endpackage : tmwf_pkg

`default_nettype wire

### design/tmwf_rank.sv
// Ranking and trimming network for one sample window.
// Pure combinational logic built from parallel comparators; no package use.
// Used by tmwf_channel.
`default_nettype none

module tmwf_rank #(
  parameter int WINDOW_LEN     = 10,
  parameter int TRIM_EACH_SIDE = 2,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic [SAMPLE_BITS-1:0] win  [WINDOW_LEN],
  output logic [SAMPLE_BITS-1:0] kept [WINDOW_LEN]
);

  localparam int RankBits = $clog2(WINDOW_LEN);

  logic [WINDOW_LEN-1:0] beats [WINDOW_LEN];
  logic [RankBits-1:0]   rank  [WINDOW_LEN];

  // Each entry's rank is the number of entries that sort ahead of it. Equal
  // values are ordered by position so every rank is distinct.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      for (int j = 0; j < WINDOW_LEN; j++) begin
        beats[i][j] = (j != i) &&
                      ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
      end
      rank[i] = RankBits'($countones(beats[i]));
    end
  end

  // Entries ranked among the smallest or largest trimmed ones read as zero.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if ((int'(rank[i]) >= TRIM_EACH_SIDE) &&
          (int'(rank[i]) < (WINDOW_LEN - TRIM_EACH_SIDE))) begin
        kept[i] = win[i];
      end else begin
        kept[i] = '0;
      end
    end
  end

endmodule : tmwf_rank

`default_nettype wire

### design/tmwf_channel.sv
// Datapath of one filter channel: sample window, rank and trim, sum, and
// division by the kept count through a constant reciprocal.
// Depends on tmwf_pkg and tmwf_rank.
`default_nettype none

module tmwf_channel
  import tmwf_pkg::*;
#(
  parameter int WINDOW_LEN     = 10,
  parameter int TRIM_EACH_SIDE = 2,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tmwf_ctrl_t             ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] average
);

  // When the trim removes everything no entry is kept, the sum is zero and a
  // divisor of one gives the required zero result.
  localparam int KeepCount = (2 * TRIM_EACH_SIDE >= WINDOW_LEN) ?
                             0 : (WINDOW_LEN - 2 * TRIM_EACH_SIDE);
  localparam int Divisor   = (KeepCount == 0) ? 1 : KeepCount;
  localparam int SumBits   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int Shift     = SumBits + $clog2(Divisor);
  localparam int RecipBits = SumBits + 1;
  localparam int ProdBits  = SumBits + RecipBits;
  // Rounded-up reciprocal; the shift is wide enough that the quotient is
  // exact for every sum without a correction step.
  localparam logic [RecipBits-1:0] Recip =
    RecipBits'(((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor));

  logic [SAMPLE_BITS-1:0] hist   [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] kept_d [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] kept   [WINDOW_LEN];
  logic [SumBits-1:0]     sum_next;
  logic [SumBits-1:0]     sum;
  logic [ProdBits-1:0]    product;

  // Window in age order: the oldest entry drops out at index zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        hist[k] <= '0;
      end
    end else if (ctrl.ld_hist) begin
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        hist[k] <= hist[k + 1];
      end
      hist[WINDOW_LEN - 1] <= sample;
    end
  end

  tmwf_rank #(
    .WINDOW_LEN     (WINDOW_LEN),
    .TRIM_EACH_SIDE (TRIM_EACH_SIDE),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_rank (
    .win  (hist),
    .kept (kept_d)
  );

  // Trimmed window register.
  always_ff @(posedge clk) begin
    if (ctrl.ld_keep) begin
      kept <= kept_d;
    end
  end

  // Sum of the kept entries; trimmed ones are already zero.
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sum_next = sum_next + SumBits'(kept[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      sum <= sum_next;
    end
  end

  // Division by the kept count as a multiply by its reciprocal.
  assign product = ProdBits'(sum) * ProdBits'(Recip);

  always_ff @(posedge clk) begin
    if (ctrl.ld_avg) begin
      average <= product[Shift +: SAMPLE_BITS];
    end
  end

endmodule : tmwf_channel

`default_nettype wire

### design/trimmed_mean_window_filter.sv
// Trimmed-mean window filter, top level: stream ports, pipeline control and
// the gas and pressure channels. Depends on tmwf_pkg and tmwf_channel.
//
// Each accepted word carries one gas and one pressure sample. Every channel
// keeps its last WINDOW_LEN samples in arrival order, ranks them with a
// network of parallel comparators, drops the TRIM_EACH_SIDE smallest and
// largest, and outputs the sum of the rest divided by their count, truncated.
// Before the window has filled, the zeros left by reset are ranked like real
// samples; reset clears both windows. The block takes one word per clock
// unless back-pressure on m_tready fills the pipeline, and passes each word
// through the four pipeline registers (window, trimmed window, sum, and the
// reciprocal multiply that divides). Each stage holds its word only while the
// next is full and stalled, so while a result waits the input keeps flowing
// until all four stages hold a word, and only then is it refused.
`default_nettype none

module trimmed_mean_window_filter
  import tmwf_pkg::*;
#(
  parameter int WINDOW_LEN     = 10,
  parameter int TRIM_EACH_SIDE = 2,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Fields from bit 0: gas_sample, pressure_sample, zero padding.
  input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Fields from bit 0: gas_average, pressure_average, zero padding.
  output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int DataBits = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  logic       v1;
  logic       v2;
  logic       v3;
  logic       v4;
  logic       rdy1;
  logic       rdy2;
  logic       rdy3;
  logic       rdy4;
  tmwf_ctrl_t ctrl;

  logic [SAMPLE_BITS-1:0] gas_average;
  logic [SAMPLE_BITS-1:0] pressure_average;

  // A stage may load when it is empty or its word moves on this cycle.
  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_tready = rdy1;
  assign m_tvalid = v4;

  assign ctrl.ld_hist = rdy1 && s_tvalid;
  assign ctrl.ld_keep = rdy2 && v1;
  assign ctrl.ld_sum  = rdy3 && v2;
  assign ctrl.ld_avg  = rdy4 && v3;

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  tmwf_channel #(
    .WINDOW_LEN     (WINDOW_LEN),
    .TRIM_EACH_SIDE (TRIM_EACH_SIDE),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_gas (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (s_tdata[SAMPLE_BITS-1:0]),
    .average (gas_average)
  );

  tmwf_channel #(
    .WINDOW_LEN     (WINDOW_LEN),
    .TRIM_EACH_SIDE (TRIM_EACH_SIDE),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_pressure (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .average (pressure_average)
  );

  // Pack the result word, padding the top bits with zeros.
  assign m_tdata = DataBits'({pressure_average, gas_average});

`ifndef SYNTHESIS
  // Input is refused only when every stage holds a word.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4))
    else $error("input stalled with an empty pipeline stage");

  // An accepted word occupies the window stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted word missing from window stage");

  // A stalled word in the sum stage stays put until the result stage frees.
  a_sum_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && v4 && !m_tready) |=> v3)
    else $error("sum stage word lost during output stall");
`endif

endmodule : trimmed_mean_window_filter

`default_nettype wire
